// ----- hw/rtl/kpd_pkg.sv -----
package kpd_pkg;

    localparam int MAX_VERTICES    = 1024;
    localparam int DEF_MAX_ENTRIES = 8192;
    localparam int CORE_MAX        = 1023;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam logic [DW-1:0] EMPTY_MARK = DW'(MAX_VERTICES);

    localparam logic [1:0] K_LOAD = 2'd0;
    localparam logic [1:0] K_RUN  = 2'd1;
    localparam logic [1:0] K_READ = 2'd2;
    localparam logic [1:0] K_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

    typedef struct packed {
        logic [1:0]    kind;
        logic [VW-1:0] vertex_id;
        logic [VW-1:0] neighbor_id;
    } t_cmd;

    typedef struct packed {
        logic [1:0]    status;
        logic [VW-1:0] core_value;
        logic [VW-1:0] max_core;
    } t_res;

endpackage

// ----- hw/rtl/kpd_if.sv -----
interface kpd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [9:0] vertex_id;
    logic [9:0] neighbor_id;
    modport source (output valid, kind, vertex_id, neighbor_id, input ready);
    modport sink (input valid, kind, vertex_id, neighbor_id, output ready);
endinterface

interface kpd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] core_value;
    logic [9:0] max_core;
    modport source (output valid, status, core_value, max_core, input ready);
    modport sink (input valid, status, core_value, max_core, output ready);
endinterface

// ----- hw/rtl/kpd_engine.sv -----
module kpd_engine #(
    parameter int MAX_ENTRIES = kpd_pkg::DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  kpd_pkg::t_cmd        i_cmd,
    input  logic [10:0]          i_vertex_count,
    input  logic                 i_out_free,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output kpd_pkg::t_res        o_res
);
    import kpd_pkg::*;

    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_LD_FILL = 24'h000002,
        S_LD_WR   = 24'h000004,
        S_RD      = 24'h000008,
        S_DONE    = 24'h000010,
        S_CLR     = 24'h000020,
        S_V0      = 24'h000040,
        S_V1      = 24'h000080,
        S_V2      = 24'h000100,
        S_INS0    = 24'h000200,
        S_INS1    = 24'h000400,
        S_INS2    = 24'h000800,
        S_SCAN0   = 24'h001000,
        S_SCAN1   = 24'h002000,
        S_UL0     = 24'h004000,
        S_UL1     = 24'h008000,
        S_UL2     = 24'h010000,
        S_POP     = 24'h020000,
        S_BEG     = 24'h040000,
        S_END     = 24'h080000,
        S_NB0     = 24'h100000,
        S_NB1     = 24'h200000,
        S_NB2     = 24'h400000,
        S_NB3     = 24'h800000
    } t_state;

    // Memories: row starts, neighbour entries, degree, core, removed flag, bucket lists.
    logic [EW-1:0] m_rs [MAX_VERTICES+1];
    logic [VW-1:0] m_nb [MAX_ENTRIES];
    logic [DW-1:0] m_dg [MAX_VERTICES];
    logic [VW-1:0] m_co [MAX_VERTICES];
    logic          m_rm [MAX_VERTICES];
    logic [DW-1:0] m_hd [MAX_VERTICES+1];
    logic [DW-1:0] m_nx [MAX_VERTICES];
    logic [DW-1:0] m_pv [MAX_VERTICES];

    logic          rs_we, nb_we, dg_we, co_we, rm_we, hd_we, nx_we, pv_we;
    logic [DW-1:0] rs_wa, rs_ra, hd_wa, hd_ra;
    logic [AW-1:0] nb_wa, nb_ra;
    logic [VW-1:0] dg_wa, dg_ra, co_wa, co_ra, rm_wa, rm_ra, nx_wa, nx_ra, pv_wa, pv_ra;
    logic [EW-1:0] rs_wd, rs_rd;
    logic [VW-1:0] nb_wd, nb_rd, co_wd, co_rd;
    logic [DW-1:0] dg_wd, dg_rd, hd_wd, hd_rd, nx_wd, nx_rd, pv_wd, pv_rd;
    logic          rm_wd, rm_rd;

    always_ff @(posedge i_clk) begin
        if (rs_we) m_rs[rs_wa] <= rs_wd;
        rs_rd <= m_rs[rs_ra];
    end
    always_ff @(posedge i_clk) begin
        if (nb_we) m_nb[nb_wa] <= nb_wd;
        nb_rd <= m_nb[nb_ra];
    end
    always_ff @(posedge i_clk) begin
        if (dg_we) m_dg[dg_wa] <= dg_wd;
        dg_rd <= m_dg[dg_ra];
    end
    always_ff @(posedge i_clk) begin
        if (co_we) m_co[co_wa] <= co_wd;
        co_rd <= m_co[co_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rm_we) m_rm[rm_wa] <= rm_wd;
        rm_rd <= m_rm[rm_ra];
    end
    always_ff @(posedge i_clk) begin
        if (hd_we) m_hd[hd_wa] <= hd_wd;
        hd_rd <= m_hd[hd_ra];
    end
    always_ff @(posedge i_clk) begin
        if (nx_we) m_nx[nx_wa] <= nx_wd;
        nx_rd <= m_nx[nx_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pv_we) m_pv[pv_wa] <= pv_wd;
        pv_rd <= m_pv[pv_ra];
    end

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [DW-1:0] r_v, n_v, r_d, n_d, r_cur, n_cur, r_p, n_p, r_nn, n_nn;
    logic [VW-1:0] r_x, n_x, r_u, n_u, r_w, n_w;
    logic [EW-1:0] r_j, n_j, r_end, n_end, r_ec, n_ec;
    logic [VW-1:0] r_last, n_last, r_largest, n_largest, r_core, n_core;
    logic          r_src_valid, n_src_valid, r_ran, n_ran, r_nbr, n_nbr, r_rm, n_rm;
    logic [1:0]    r_status, n_status;

    logic [DW-1:0]    cnt;
    logic [EW-1:0]    diff;
    logic [EW+DW-1:0] diff_ext;
    logic [DW-1:0]    deg_clamp;
    logic [VW-1:0]    core_sat;

    assign cnt       = (i_vertex_count > DW'(MAX_VERTICES)) ? DW'(MAX_VERTICES)
                                                            : i_vertex_count;
    assign diff      = rs_rd - r_j;
    assign diff_ext  = {{DW{1'b0}}, diff};
    assign deg_clamp = (diff_ext > (EW+DW)'(MAX_VERTICES)) ? DW'(MAX_VERTICES)
                                                           : diff_ext[DW-1:0];
    assign core_sat  = (r_cur > DW'(CORE_MAX)) ? VW'(CORE_MAX) : r_cur[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ec        <= '0;
            r_src_valid <= 1'b0;
            r_ran       <= 1'b0;
            r_largest   <= '0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_ec        <= n_ec;
            r_src_valid <= n_src_valid;
            r_ran       <= n_ran;
            r_largest   <= n_largest;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_v      <= n_v;
        r_d      <= n_d;
        r_cur    <= n_cur;
        r_p      <= n_p;
        r_nn     <= n_nn;
        r_x      <= n_x;
        r_u      <= n_u;
        r_w      <= n_w;
        r_j      <= n_j;
        r_end    <= n_end;
        r_core   <= n_core;
        r_nbr    <= n_nbr;
        r_rm     <= n_rm;
        r_status <= n_status;
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_v = r_v; n_d = r_d; n_cur = r_cur;
        n_p = r_p; n_nn = r_nn; n_x = r_x; n_u = r_u; n_w = r_w; n_j = r_j;
        n_end = r_end; n_ec = r_ec; n_last = r_last; n_largest = r_largest;
        n_core = r_core; n_src_valid = r_src_valid; n_ran = r_ran; n_nbr = r_nbr;
        n_rm = r_rm; n_status = r_status;
        rs_we = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra = '0;
        nb_we = 1'b0; nb_wa = '0; nb_wd = '0; nb_ra = '0;
        dg_we = 1'b0; dg_wa = '0; dg_wd = '0; dg_ra = '0;
        co_we = 1'b0; co_wa = '0; co_wd = '0; co_ra = '0;
        rm_we = 1'b0; rm_wa = '0; rm_wd = 1'b0; rm_ra = '0;
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                n_status = ST_OK;
                n_core   = '0;
                n_cmd    = i_cmd;
                if (i_start) begin
                    case (i_cmd.kind)
                        K_LOAD: begin
                            n_state = S_DONE;
                            if ({1'b0, i_cmd.vertex_id} >= cnt ||
                                {1'b0, i_cmd.neighbor_id} >= cnt) begin
                                n_status = ST_RANGE;
                            end else if (r_ec >= EW'(MAX_ENTRIES) ||
                                         (r_src_valid && i_cmd.vertex_id < r_last)) begin
                                n_status = ST_ORDER;
                            end else if (!r_src_valid) begin
                                // The first entry also fixes the start of row zero.
                                n_v     = '0;
                                n_state = S_LD_FILL;
                            end else if (i_cmd.vertex_id > r_last) begin
                                n_v     = {1'b0, r_last} + DW'(2);
                                n_state = S_LD_FILL;
                            end else begin
                                n_state = S_LD_WR;
                            end
                        end
                        K_RUN: begin
                            n_v       = '0;
                            n_largest = '0;
                            n_ran     = 1'b1;
                            n_state   = S_CLR;
                        end
                        K_READ: begin
                            if ({1'b0, i_cmd.vertex_id} >= cnt) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                co_ra   = i_cmd.vertex_id;
                                n_state = S_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_FILL: begin
                if (r_v <= {1'b0, r_cmd.vertex_id}) begin
                    rs_we = 1'b1; rs_wa = r_v; rs_wd = r_ec;
                    n_v   = r_v + DW'(1);
                end else begin
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                nb_we = 1'b1; nb_wa = r_ec[AW-1:0]; nb_wd = r_cmd.neighbor_id;
                rs_we = 1'b1; rs_wa = {1'b0, r_cmd.vertex_id} + DW'(1);
                rs_wd = r_ec + EW'(1);
                n_ec        = r_ec + EW'(1);
                n_last      = r_cmd.vertex_id;
                n_src_valid = 1'b1;
                n_state     = S_DONE;
            end
            S_RD: begin
                n_core  = r_ran ? co_rd : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            S_CLR: begin
                hd_we = 1'b1; hd_wa = r_v; hd_wd = EMPTY_MARK;
                if (r_v == DW'(MAX_VERTICES)) begin
                    n_v     = '0;
                    n_cur   = '0;
                    n_nbr   = 1'b0;
                    n_state = S_V0;
                end else begin
                    n_v = r_v + DW'(1);
                end
            end
            S_V0: begin
                co_we = 1'b1; co_wa = r_v[VW-1:0]; co_wd = '0;
                n_x = r_v[VW-1:0];
                if (r_v < cnt) begin
                    if (r_src_valid && r_v <= {1'b0, r_last}) begin
                        rs_ra   = r_v;
                        n_state = S_V1;
                    end else begin
                        n_d     = '0;
                        n_state = S_INS0;
                    end
                end else begin
                    dg_we = 1'b1; dg_wa = r_v[VW-1:0]; dg_wd = '0;
                    rm_we = 1'b1; rm_wa = r_v[VW-1:0]; rm_wd = 1'b1;
                    if (r_v == DW'(MAX_VERTICES - 1)) n_state = S_SCAN0;
                    else n_v = r_v + DW'(1);
                end
            end
            S_V1: begin
                rs_ra   = r_v + DW'(1);
                n_j     = rs_rd;
                n_state = S_V2;
            end
            S_V2: begin
                n_d     = deg_clamp;
                n_state = S_INS0;
            end
            S_INS0: begin
                dg_we = 1'b1; dg_wa = r_x; dg_wd = r_d;
                rm_we = 1'b1; rm_wa = r_x; rm_wd = 1'b0;
                hd_ra = r_d;
                n_state = S_INS1;
            end
            S_INS1: begin
                pv_we = 1'b1; pv_wa = r_x; pv_wd = EMPTY_MARK;
                nx_we = 1'b1; nx_wa = r_x; nx_wd = hd_rd;
                hd_we = 1'b1; hd_wa = r_d; hd_wd = {1'b0, r_x};
                n_nn  = hd_rd;
                if (hd_rd != EMPTY_MARK) begin
                    n_state = S_INS2;
                end else if (r_nbr) begin
                    n_j = r_j + EW'(1); n_state = S_NB0;
                end else if (r_v == DW'(MAX_VERTICES - 1)) begin
                    n_state = S_SCAN0;
                end else begin
                    n_v = r_v + DW'(1); n_state = S_V0;
                end
            end
            S_INS2: begin
                pv_we = 1'b1; pv_wa = r_nn[VW-1:0]; pv_wd = {1'b0, r_x};
                if (r_nbr) begin
                    n_j = r_j + EW'(1); n_state = S_NB0;
                end else if (r_v == DW'(MAX_VERTICES - 1)) begin
                    n_state = S_SCAN0;
                end else begin
                    n_v = r_v + DW'(1); n_state = S_V0;
                end
            end
            S_SCAN0: begin
                if (r_cur > DW'(MAX_VERTICES)) begin
                    n_state = S_DONE;
                end else begin
                    hd_ra   = r_cur;
                    n_state = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (hd_rd == EMPTY_MARK) begin
                    n_cur   = r_cur + DW'(1);
                    n_state = S_SCAN0;
                end else begin
                    n_u     = hd_rd[VW-1:0];
                    n_x     = hd_rd[VW-1:0];
                    n_d     = r_cur;
                    n_nbr   = 1'b0;
                    n_state = S_UL0;
                end
            end
            S_UL0: begin
                pv_ra   = r_x;
                n_state = S_UL1;
            end
            S_UL1: begin
                n_p     = pv_rd;
                nx_ra   = r_x;
                n_state = S_UL2;
            end
            S_UL2: begin
                if (r_p != EMPTY_MARK) begin
                    nx_we = 1'b1; nx_wa = r_p[VW-1:0]; nx_wd = nx_rd;
                end else begin
                    hd_we = 1'b1; hd_wa = r_d; hd_wd = nx_rd;
                end
                if (nx_rd != EMPTY_MARK) begin
                    pv_we = 1'b1; pv_wa = nx_rd[VW-1:0]; pv_wd = r_p;
                end
                if (r_nbr) begin
                    n_d     = r_d - DW'(1);
                    n_state = S_INS0;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                rm_we = 1'b1; rm_wa = r_u; rm_wd = 1'b1;
                if (r_cur == '0) begin
                    n_state = S_SCAN0;
                end else begin
                    co_we = 1'b1; co_wa = r_u; co_wd = core_sat;
                    if (core_sat > r_largest) n_largest = core_sat;
                    if (r_src_valid && r_u <= r_last) begin
                        rs_ra   = {1'b0, r_u};
                        n_state = S_BEG;
                    end else begin
                        n_state = S_SCAN0;
                    end
                end
            end
            S_BEG: begin
                rs_ra   = {1'b0, r_u} + DW'(1);
                n_j     = rs_rd;
                n_state = S_END;
            end
            S_END: begin
                n_end   = rs_rd;
                n_nbr   = 1'b1;
                n_state = S_NB0;
            end
            S_NB0: begin
                if (r_j < r_end) begin
                    nb_ra   = r_j[AW-1:0];
                    n_state = S_NB1;
                end else begin
                    n_state = S_SCAN0;
                end
            end
            S_NB1: begin
                if ({1'b0, nb_rd} < cnt) begin
                    n_w     = nb_rd;
                    rm_ra   = nb_rd;
                    n_state = S_NB2;
                end else begin
                    n_j     = r_j + EW'(1);
                    n_state = S_NB0;
                end
            end
            S_NB2: begin
                n_rm    = rm_rd;
                dg_ra   = r_w;
                n_state = S_NB3;
            end
            S_NB3: begin
                if (!r_rm && dg_rd > r_cur) begin
                    n_x     = r_w;
                    n_d     = dg_rd;
                    n_state = S_UL0;
                end else begin
                    n_j     = r_j + EW'(1);
                    n_state = S_NB0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, core_value: r_core, max_core: r_largest};

endmodule

// ----- hw/rtl/kcore_peeling_decomposition.sv -----
// k-core decomposition engine. Adjacency entries are loaded one item at a time in
// ascending source order into on-chip stores; a run item peels the whole stored
// graph with bucket lists and leaves a core number per vertex, and a read item
// returns one of them. Every memory has a single registered read port, so each
// step is a short sequence of accesses. A load that opens a new source row also
// fills in the skipped row starts. A run first clears the bucket heads, then
// builds the buckets, scans them, removes vertices, visits their stored entries
// and decrements neighbour degrees. The vertex count register is written over the
// APB port at address 0; the user must write it only while idle, as the block
// itself does not enforce this.
module kcore_peeling_decomposition #(
    parameter int MAX_ENTRIES = kpd_pkg::DEF_MAX_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpd_in_if.sink      i_in,
    kpd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kpd_pkg::*;

    logic [10:0] r_vertex_count;
    logic        r_out_valid;
    t_res        r_out;
    logic        idle, res_valid, out_free, start;
    t_res        res;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 11'(MAX_VERTICES);
        end else if (psel && penable && pwrite && paddr == ADDR_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_VERTEX_COUNT) ? {21'd0, r_vertex_count} : 32'd0;

    assign start    = i_in.valid && idle;
    assign out_free = !r_out_valid || o_out.ready;
    assign cmd      = '{kind: i_in.kind, vertex_id: i_in.vertex_id,
                        neighbor_id: i_in.neighbor_id};

    kpd_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cmd          (cmd),
        .i_vertex_count (r_vertex_count),
        .i_out_free     (out_free),
        .o_idle         (idle),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) r_out <= res;
    end

    assign i_in.ready       = idle;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.core_value = r_out.core_value;
    assign o_out.max_core   = r_out.max_core;

endmodule

// ----- hw/rtl/kpd_checker.sv -----
module kpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_kind,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [9:0] i_core_value,
    input logic [9:0] i_max_core
);
    import kpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_core_value) && $stable(i_max_core))
        else $error("result item changed while stalled");

    // An accepted item of a used kind leaves the input not ready in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_kind != K_NONE |=> !i_in_ready)
        else $error("input taken again straight after an item");

    a_fail_zero_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_core_value == 10'd0)
        else $error("failed item carries a core value");

endmodule

bind kcore_peeling_decomposition kpd_checker u_kpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_kind       (i_in.kind),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_core_value (o_out.core_value),
    .i_max_core   (o_out.max_core)
);

// ----- sim/kpd_checker.sv -----
module kpd_scoreboard #(
    parameter int ENTRY_LIMIT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpd_in_if           i_in,
    kpd_out_if          i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_waiting
);
    import kpd_pkg::*;

    localparam int NIL = MAX_VERTICES;

    int unsigned vcount;
    int unsigned row_base [MAX_VERTICES+1];
    int unsigned nbr      [ENTRY_LIMIT];
    int unsigned n_entries;
    int unsigned deg      [MAX_VERTICES];
    int unsigned core_num [MAX_VERTICES];
    bit          gone     [MAX_VERTICES];
    int unsigned head     [MAX_VERTICES+1];
    int unsigned nxt      [MAX_VERTICES];
    int unsigned prv      [MAX_VERTICES];
    int unsigned top_core;
    int unsigned last_src;
    bit          src_seen;
    t_res        core_answers_q [$];

    assign o_waiting = core_answers_q.size();

    function automatic int unsigned live_count();
        return (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
    endfunction

    function automatic int unsigned row_len(int unsigned v);
        if (!src_seen || v > last_src)
            return 0;
        return row_base[v+1] - row_base[v];
    endfunction

    function automatic void bucket_push(int unsigned v, int unsigned d);
        int unsigned h;
        h = head[d];
        prv[v] = NIL;
        nxt[v] = h;
        if (h != NIL)
            prv[h] = v;
        head[d] = v;
    endfunction

    function automatic void bucket_drop(int unsigned v, int unsigned d);
        int unsigned p;
        int unsigned q;
        p = prv[v];
        q = nxt[v];
        if (p != NIL)
            nxt[p] = q;
        else
            head[d] = q;
        if (q != NIL)
            prv[q] = p;
    endfunction

    // Peels the whole stored graph, lowest current degree first, in the same
    // bucket order as the hardware so that ties resolve identically.
    function automatic void peel_graph();
        int unsigned n;
        int unsigned cur;
        int unsigned u;
        int unsigned w;
        int unsigned d;
        int unsigned j;
        int unsigned stop;
        n = live_count();
        cur = 0;
        for (int v = 0; v <= MAX_VERTICES; v++)
            head[v] = NIL;
        top_core = 0;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            core_num[v] = 0;
            if (v < n) begin
                d = row_len(v);
                if (d > MAX_VERTICES)
                    d = MAX_VERTICES;
                deg[v] = d;
                gone[v] = 0;
                bucket_push(v, d);
            end else begin
                deg[v] = 0;
                gone[v] = 1;
            end
        end
        forever begin
            while (cur <= MAX_VERTICES && head[cur] == NIL)
                cur++;
            if (cur > MAX_VERTICES)
                break;
            u = head[cur];
            bucket_drop(u, cur);
            gone[u] = 1;
            if (cur == 0)
                continue;
            core_num[u] = (cur > CORE_MAX) ? CORE_MAX : cur;
            if (core_num[u] > top_core)
                top_core = core_num[u];
            j = row_base[u];
            stop = j + row_len(u);
            for (; j < stop && j < ENTRY_LIMIT; j++) begin
                w = nbr[j];
                if (w < n && !gone[w] && deg[w] > cur) begin
                    bucket_drop(w, deg[w]);
                    deg[w]--;
                    bucket_push(w, deg[w]);
                end
            end
        end
    endfunction

    function automatic t_res predict_answer(logic [1:0] kind, int unsigned vid,
                                            int unsigned nid);
        t_res r;
        int unsigned n;
        int unsigned w;
        n = live_count();
        r = '0;
        if (kind == K_LOAD) begin
            if (vid >= n || nid >= n) begin
                r.status = ST_RANGE;
            end else if (n_entries >= ENTRY_LIMIT || (src_seen && vid < last_src)) begin
                r.status = ST_ORDER;
            end else begin
                // Rows skipped over start where the new entry lands.
                w = src_seen ? last_src + 2 : 1;
                if (!src_seen || vid > last_src)
                    for (; w <= vid; w++)
                        row_base[w] = n_entries;
                nbr[n_entries] = nid;
                n_entries++;
                row_base[vid+1] = n_entries;
                last_src = vid;
                src_seen = 1;
            end
        end else if (kind == K_RUN) begin
            peel_graph();
        end else begin
            if (vid >= n)
                r.status = ST_RANGE;
            else
                r.core_value = VW'(core_num[vid]);
        end
        r.max_core = VW'(top_core);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            vcount = MAX_VERTICES;
            for (int v = 0; v <= MAX_VERTICES; v++) begin
                row_base[v] = 0;
                head[v] = NIL;
            end
            for (int v = 0; v < MAX_VERTICES; v++) begin
                deg[v] = 0;
                core_num[v] = 0;
                gone[v] = 0;
            end
            n_entries = 0;
            top_core = 0;
            last_src = 0;
            src_seen = 0;
            core_answers_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == ADDR_VERTEX_COUNT)
                vcount = i_pwdata[10:0];
            if (i_in.valid && i_in.ready && i_in.kind != K_NONE)
                core_answers_q = {core_answers_q,
                                  predict_answer(i_in.kind, i_in.vertex_id,
                                                 i_in.neighbor_id)};
            if (i_out.valid && i_out.ready) begin
                got.status = i_out.status;
                got.core_value = i_out.core_value;
                got.max_core = i_out.max_core;
                if (core_answers_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d core=%0d max=%0d",
                             $time, got.status, got.core_value, got.max_core);
                    o_fail_count++;
                end else begin
                    want = core_answers_q.pop_front();
                    if (got.status !== want.status || got.core_value !== want.core_value
                            || got.max_core !== want.max_core) begin
                        $display("%0t: mismatch, expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.status, want.core_value, want.max_core,
                                 got.status, got.core_value, got.max_core);
                        o_fail_count++;
                    end
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

// ----- sim/kcore_peeling_decomposition_tb.sv -----
module kcore_peeling_decomposition_tb;
    import kpd_pkg::*;

    localparam int ENTRY_LIMIT = 512;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          waiting;
    bit          calm;
    bit          squeeze;
    int unsigned cur_src;
    int unsigned vc;

    kpd_in_if  in_ch ();
    kpd_out_if out_ch ();

    kcore_peeling_decomposition #(.MAX_ENTRIES(ENTRY_LIMIT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    kpd_scoreboard #(.ENTRY_LIMIT(ENTRY_LIMIT)) u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_waiting(waiting)
    );

    initial i_clk = 0;
    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        bit squeezed;
        int unsigned gap;
        squeezed = 0;
        out_ch.ready <= 0;
        wait (i_rst_n);
        forever begin
            if (squeeze && !squeezed) begin
                squeezed = 1;
                out_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 0;
                    repeat (gap) @(posedge i_clk);
                end
                out_ch.ready <= 1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [1:0] kind, int unsigned vid, int unsigned nid);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.kind <= kind;
        in_ch.vertex_id <= vid[9:0];
        in_ch.neighbor_id <= nid[9:0];
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Register writes only once the block has drained.
    task automatic set_vertex_count(int unsigned value);
        in_ch.valid <= 0;
        @(posedge i_clk);
        wait (waiting == 0);
        repeat (50) @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_VERTEX_COUNT;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge i_clk);
        vc = value;
    endtask

    task automatic random_load();
        int unsigned n;
        int unsigned nid;
        n = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
        if ($urandom_range(99) < 88 && cur_src < n) begin
            if ($urandom_range(3) == 0 && cur_src + 1 < n)
                cur_src = cur_src + $urandom_range(1, 3);
            if (cur_src >= n)
                cur_src = n - 1;
            nid = cur_src + $urandom_range(0, 30);
            nid = (nid < 15) ? 0 : nid - 15;
            if (nid >= n)
                nid = n - 1;
            send_item(K_LOAD, cur_src, nid);
        end else if ($urandom_range(1) == 0) begin
            send_item(K_LOAD, $urandom_range(0, cur_src), $urandom_range(1023));
        end else begin
            send_item(K_LOAD, $urandom_range(n < 1023 ? n : 1023, 1023),
                      $urandom_range(1023));
        end
    endtask

    task automatic random_read();
        if ($urandom_range(19) == 0)
            send_item(K_NONE, $urandom_range(1023), $urandom_range(1023));
        else if ($urandom_range(9) == 0)
            send_item(K_READ, $urandom_range(1023), $urandom_range(1023));
        else
            send_item(K_READ, $urandom_range(0, cur_src + 20 < 1023 ? cur_src + 20 : 1023),
                      $urandom_range(1023));
    endtask

    initial begin
        in_ch.valid <= 0;
        in_ch.kind <= K_LOAD;
        in_ch.vertex_id <= '0;
        in_ch.neighbor_id <= '0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= '0;
        pwdata <= '0;
        squeeze = 0;
        calm = 0;
        vc = MAX_VERTICES;
        cur_src = 5;
        i_rst_n <= 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Empty graph, then a small dense cluster with a self loop and disorder.
        send_item(K_RUN, 0, 0);
        send_item(K_READ, 0, 0);
        send_item(K_READ, 1023, 1023);
        send_item(K_NONE, 0, 0);
        send_item(K_LOAD, 2, 3);
        send_item(K_LOAD, 2, 2);
        send_item(K_LOAD, 2, 4);
        send_item(K_LOAD, 3, 2);
        send_item(K_LOAD, 3, 4);
        send_item(K_LOAD, 4, 2);
        send_item(K_LOAD, 4, 3);
        send_item(K_LOAD, 4, 1023);
        send_item(K_LOAD, 1, 0);
        send_item(K_LOAD, 5, 4);
        send_item(K_RUN, 0, 0);
        send_item(K_READ, 2, 0);
        send_item(K_READ, 4, 0);
        send_item(K_READ, 1023, 0);

        set_vertex_count(1);
        send_item(K_LOAD, 0, 0);
        send_item(K_LOAD, 5, 0);
        send_item(K_RUN, 0, 0);
        send_item(K_READ, 0, 0);
        send_item(K_READ, 1, 0);

        set_vertex_count(0);
        send_item(K_LOAD, 0, 0);
        send_item(K_READ, 0, 0);
        send_item(K_RUN, 0, 0);

        set_vertex_count(2047);
        send_item(K_RUN, 0, 0);
        send_item(K_READ, 3, 0);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 5)
                set_vertex_count(cur_src / 2 + 1);
            else if ($urandom_range(2) == 0 || cur_src + 40 >= MAX_VERTICES)
                set_vertex_count(MAX_VERTICES);
            else
                set_vertex_count(cur_src + $urandom_range(40, 200) > MAX_VERTICES ?
                                 MAX_VERTICES : cur_src + $urandom_range(40, 200));
            calm = (phase == 1);
            repeat (90) random_load();
            if (phase == 2)
                squeeze = 1;
            repeat (30) random_read();
            send_item(K_RUN, $urandom_range(1023), $urandom_range(1023));
            repeat (20) random_read();
        end

        in_ch.valid <= 0;
        @(posedge i_clk);
        wait (waiting == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- kcore_peeling_decomposition.f -----
hw/rtl/kpd_pkg.sv
hw/rtl/kpd_if.sv
hw/rtl/kpd_engine.sv
hw/rtl/kcore_peeling_decomposition.sv
hw/rtl/kpd_checker.sv
sim/kpd_checker.sv
sim/kcore_peeling_decomposition_tb.sv
